// ===== hdl/dfw_pkg.sv =====
// dfw_pkg: shared widths, register indexes and reset values for the
// disparity forward warp row unit. No dependencies.
`timescale 1ns / 1ps

package dfw_pkg;

   // default row buffer depth
   localparam int DEF_MAX_ROW_WIDTH = 2048;

   // port widths
   localparam int COLUMN_W = 11;
   localparam int DISP_W   = 16;
   localparam int CHAN_W   = 8;
   localparam int COLOUR_W = 3 * CHAN_W;
   localparam int VO_W     = 7;
   localparam int GAIN_W   = 16;
   localparam int ROWW_W   = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // shift arithmetic: disparity * gain, then * |view offset|, Q23.16
   localparam int PROD1_W = DISP_W + GAIN_W;
   localparam int PROD2_W = PROD1_W + VO_W;
   localparam int FRAC_W  = 16;
   localparam int MAG_W   = PROD2_W - FRAC_W;
   localparam int TGT_W   = MAG_W + 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH   = 2'd2;

   // register reset values
   localparam logic signed [VO_W-1:0] VIEW_OFFSET_RST = 7'sd0;
   localparam logic [GAIN_W-1:0]      GAIN_RST        = 16'd256;
   localparam logic [ROWW_W-1:0]      ROW_WIDTH_RST   = 12'd2048;

   // item function codes
   localparam logic FUNC_SCATTER = 1'b0;
   localparam logic FUNC_READOUT = 1'b1;

   // target column and range check handed from the shift unit
   typedef struct packed {
      logic                    in_range;
      logic signed [TGT_W-1:0] target;
   } target_type;

endpackage

// ===== hdl/dfw_target_calc.sv =====
// dfw_target_calc: two-stage shift computation and target range check.
// Depends on dfw_pkg.
`timescale 1ns / 1ps

module dfw_target_calc
   import dfw_pkg::*;
#(
   parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic                   step,
   input  logic                   func,
   input  logic [COLUMN_W-1:0]    column,
   input  logic [DISP_W-1:0]      disparity,
   input  logic signed [VO_W-1:0] view_offset,
   input  logic [GAIN_W-1:0]      gain,
   input  logic [ROWW_W-1:0]      row_width,
   output target_type             result
);

   logic [PROD1_W-1:0]      prod1_ff;
   logic [VO_W-1:0]         mag_vo;
   logic [PROD2_W-1:0]      prod2;
   logic [MAG_W-1:0]        mag;
   logic signed [TGT_W-1:0] shift;
   logic signed [TGT_W-1:0] target;
   logic [TGT_W-1:0]        row_ext;
   logic [TGT_W-1:0]        width_in_use;
   target_type              result_ff;
   target_type              result_in;

   always_ff @(posedge clock) begin
      if (load) begin
         prod1_ff <= PROD1_W'(disparity) * PROD1_W'(gain);
      end
      if (step) begin
         result_ff <= result_in;
      end
   end

   always_comb begin
      mag_vo  = view_offset[VO_W-1] ? VO_W'(-view_offset) : VO_W'(view_offset);
      prod2   = PROD2_W'(prod1_ff) * PROD2_W'(mag_vo);
      mag     = prod2[PROD2_W-1:FRAC_W];
      // truncate toward zero: negate the magnitude for a negative offset
      shift   = view_offset[VO_W-1] ? -$signed(TGT_W'(mag)) : $signed(TGT_W'(mag));
      if (func == FUNC_READOUT) begin
         target = $signed(TGT_W'(column));
      end else begin
         target = $signed(TGT_W'(column)) + shift;
      end
      row_ext = TGT_W'(row_width);
      width_in_use = (row_ext < TGT_W'(MAX_ROW_WIDTH)) ? row_ext : TGT_W'(MAX_ROW_WIDTH);
      result_in.target   = target;
      result_in.in_range = !target[TGT_W-1] && (TGT_W'(target) < width_in_use);
   end

   assign result = result_ff;

endmodule

// ===== hdl/disparity_forward_warp_row_unit.sv =====
// A readout word is shown on rsp_ once its request has passed the multiply, z-buffer
// read and update states; update waits while the previous response word is untaken.
// Items are taken one at a time: no new request is accepted until the last one is
//   through. Reset: synchronous; control registers take their reset values, then a
//   clearing pass writes every row buffer entry with req_ready low; csr_ writes still apply.
// Depends on dfw_pkg and dfw_target_calc.
`timescale 1ns / 1ps

module disparity_forward_warp_row_unit
   import dfw_pkg::*;
#(
   parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [COLUMN_W-1:0]   req_column,
   input  logic [DISP_W-1:0]     req_disparity,
   input  logic                  req_disparity_invalid,
   input  logic [CHAN_W-1:0]     req_red_in,
   input  logic [CHAN_W-1:0]     req_green_in,
   input  logic [CHAN_W-1:0]     req_blue_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAN_W-1:0]     rsp_red_out,
   output logic [CHAN_W-1:0]     rsp_green_out,
   output logic [CHAN_W-1:0]     rsp_blue_out,
   output logic                  rsp_hole,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W  = $clog2(MAX_ROW_WIDTH);
   localparam int ENTRY_W = DISP_W + COLOUR_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_ROW_WIDTH - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_UPD   = 3'd4;

   // entry: depth in the upper bits, colour below; depth zero marks a hole
   logic [ENTRY_W-1:0] row_mem [MAX_ROW_WIDTH];

   logic [2:0]              state_ff, state_in;
   logic [ADDR_W-1:0]       clear_cnt_ff, clear_cnt_in;
   logic signed [VO_W-1:0]  view_offset_ff;
   logic [GAIN_W-1:0]       gain_ff;
   logic [ROWW_W-1:0]       row_width_ff;

   logic                    func_ff;
   logic [COLUMN_W-1:0]     column_ff;
   logic [DISP_W-1:0]       disp_ff;
   logic                    invalid_ff;
   logic [COLOUR_W-1:0]     colour_ff;

   logic [ENTRY_W-1:0]      rd_data_ff;
   logic [DISP_W-1:0]       rd_depth;
   logic [COLOUR_W-1:0]     rd_colour;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COLOUR_W-1:0]     rsp_colour_ff;
   logic                    rsp_hole_ff;

   logic                    accept;
   logic                    out_free;
   logic                    upd_go;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_addr;
   logic [ENTRY_W-1:0]      mem_wdata;
   target_type              tgt;

   // the first product is taken straight from the request word as it is accepted
   dfw_target_calc #(
      .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
   ) u_target (
      .clock         (clock),
      .load          (accept),
      .step          (state_ff == ST_MUL),
      .func          (func_ff),
      .column        (column_ff),
      .disparity     (req_disparity),
      .view_offset   (view_offset_ff),
      .gain          (gain_ff),
      .row_width     (row_width_ff),
      .result        (tgt)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // a readout holds in update until the response register is free
   assign upd_go    = (state_ff == ST_UPD) && (func_ff == FUNC_SCATTER || out_free);
   assign rd_depth  = rd_data_ff[ENTRY_W-1:COLOUR_W];
   assign rd_colour = rd_data_ff[COLOUR_W-1:0];

   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_READ;
         ST_READ: state_in = ST_UPD;
         ST_UPD: begin
            if (upd_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = tgt.target[ADDR_W-1:0];
      mem_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         mem_we   = 1'b1;
         mem_addr = clear_cnt_ff;
      end else if (upd_go && tgt.in_range) begin
         if (func_ff == FUNC_READOUT) begin
            mem_we = 1'b1;
         end else begin
            mem_we    = !invalid_ff && (disp_ff > rd_depth);
            mem_wdata = {disp_ff, colour_ff};
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (upd_go && func_ff == FUNC_READOUT) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= row_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clear_cnt_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         view_offset_ff <= VIEW_OFFSET_RST;
         gain_ff        <= GAIN_RST;
         row_width_ff   <= ROW_WIDTH_RST;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_VIEW_OFFSET: view_offset_ff <= $signed(csr_wdata[VO_W-1:0]);
               CSR_GAIN:        gain_ff        <= csr_wdata[GAIN_W-1:0];
               CSR_ROW_WIDTH:   row_width_ff   <= csr_wdata[ROWW_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // hold the request word for the duration of the item
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff    <= req_func;
         column_ff  <= req_column;
         disp_ff    <= req_disparity;
         invalid_ff <= req_disparity_invalid;
         colour_ff  <= {req_blue_in, req_green_in, req_red_in};
      end
      if (upd_go && func_ff == FUNC_READOUT) begin
         if (tgt.in_range) begin
            rsp_colour_ff <= rd_colour;
            rsp_hole_ff   <= (rd_depth == '0);
         end else begin
            rsp_colour_ff <= '0;
            rsp_hole_ff   <= 1'b1;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_colour_ff[CHAN_W-1:0];
   assign rsp_green_out = rsp_colour_ff[2*CHAN_W-1:CHAN_W];
   assign rsp_blue_out  = rsp_colour_ff[3*CHAN_W-1:2*CHAN_W];
   assign rsp_hole      = rsp_hole_ff;

endmodule

// ===== hdl/dfw_checker.sv =====
// dfw_checker: port-level checks on the disparity forward warp row unit,
// bound to the top level. Depends on dfw_pkg.
`timescale 1ns / 1ps

module dfw_checker
   import dfw_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAN_W-1:0] rsp_red_out,
   input logic [CHAN_W-1:0] rsp_green_out,
   input logic [CHAN_W-1:0] rsp_blue_out,
   input logic              rsp_hole
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_out)
         && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_hole))
      else $error("response word changed while stalled");

   // a hole always reads out black
   a_hole_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hole |-> rsp_red_out == '0 && rsp_green_out == '0
         && rsp_blue_out == '0)
      else $error("hole returned with nonzero colour");

   // clearing pass keeps requests out right after reset
   a_clear_pass: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // an accepted item occupies the unit for its multiply, read and update cycles
   a_item_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("new request taken while an item is in flight");

endmodule

bind disparity_forward_warp_row_unit dfw_checker u_dfw_checker (.*);
